// ===== src/fcv_pkg.sv =====
// Package for the flash coincidence veto block.
// Holds the transaction structs, command and register codes, the state enum and sizes.
// No dependencies.
package fcv_pkg;

  // Depth of the beam window store.
  localparam int MAX_WINDOWS = 32;
  localparam int WIN_IDX_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int WIN_CNT_W   = $clog2(MAX_WINDOWS + 1);

  localparam int TIME_W   = 24;
  localparam int CHARGE_W = 24;
  localparam int TAG_W    = 16;
  localparam int VETO_W   = 16;
  localparam int RATIO_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Command codes.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_COSMIC = 2'd2;
  localparam logic [1:0] CMD_BEAM   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VETO_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PE_RATIO    = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [VETO_W-1:0]  VETO_WINDOW_RESET = 16'd2400;
  localparam logic [RATIO_W-1:0] PE_RATIO_RESET    = 8'd179;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [TIME_W-1:0]  flash_time;
    logic signed [TIME_W-1:0]  window_low;
    logic signed [TIME_W-1:0]  window_high;
    logic [CHARGE_W-1:0]       photo_charge;
    logic [TAG_W-1:0]          flash_tag;
  } fcv_in_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag_out;
    logic             kept;
    logic             from_beam;
    logic             window_overflow;
  } fcv_out_t;

  // One stored beam window.
  typedef struct packed {
    logic signed [TIME_W-1:0] low;
    logic signed [TIME_W-1:0] high;
  } window_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_JUDGE
  } fcv_state_t;

endpackage

// ===== src/fcv_window_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used as the beam window store. No dependencies.
module fcv_window_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/flash_coincidence_veto_unit.sv =====
// Top level of the flash coincidence veto block.
// Depends on fcv_pkg and fcv_window_ram.
//
// Channel   | Signals                          | Handshake
// ----------+----------------------------------+-------------------------------------
// request   | start, busy, request (fcv_in_t)  | accepted when start && !busy
// result    | done, result (fcv_out_t)         | valid for the one cycle done is high
// config    | cfg_we, cfg_index, cfg_data      | written when cfg_we is high
//
// Clear and window load never raise busy.
// A cosmic flash scans the window store one entry per cycle through the RAM read port,
// then is judged once the last read is back; with an empty store it is judged at once.
// A beam flash is judged in ST_JUDGE. The result appears in the cycle in which busy falls.
// Reset (rst, synchronous) empties the store, drops the tracked cosmic flash and
// restores the register defaults. The receiver cannot stall: done is a single pulse.
module flash_coincidence_veto_unit
  import fcv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  fcv_in_t               request,
  output logic                  done,
  output fcv_out_t              result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fcv_state_t state, state_next;

  logic [VETO_W-1:0]        veto_window;
  logic [RATIO_W-1:0]       pe_ratio;
  logic [WIN_CNT_W-1:0]     window_count;
  logic signed [TIME_W-1:0] latest_time;
  logic [CHARGE_W-1:0]      latest_charge;
  logic                     latest_valid;
  logic                     overflow;

  fcv_in_t                  item;
  logic [WIN_CNT_W-1:0]     issue_cnt;
  logic                     rd_pend;
  logic                     hit;

  logic                     accept;
  logic                     store_full;
  logic                     ram_wr_en;
  logic                     ram_rd_en;
  window_entry_t            ram_wr_data;
  window_entry_t            ram_rd_data;
  logic                     finish;
  logic                     window_match;

  logic signed [TIME_W:0]   dt;
  logic                     dt_inside;
  logic [31:0]              lhs;
  logic [31:0]              rhs;
  logic                     beam_kept;
  logic                     cosmic_kept;
  logic                     cosmic_track;

  assign accept     = start && !busy;
  assign busy       = (state != ST_IDLE);
  assign store_full = (window_count == WIN_CNT_W'(MAX_WINDOWS));

  // Window store.
  assign ram_wr_en   = accept && (request.cmd == CMD_LOAD) && !store_full;
  assign ram_wr_data = '{low: request.window_low, high: request.window_high};

  fcv_window_ram #(
    .WIDTH ($bits(window_entry_t)),
    .DEPTH (MAX_WINDOWS)
  ) u_window_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (window_count[WIN_IDX_W-1:0]),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (issue_cnt[WIN_IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Next state and scan control.
  always_comb begin
    state_next = state;
    ram_rd_en  = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (request.cmd)
            CMD_COSMIC: state_next = ST_SCAN;
            CMD_BEAM:   state_next = ST_JUDGE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue_cnt < window_count) begin
          ram_rd_en = 1'b1;
        end else if (!rd_pend) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_JUDGE: begin
        finish     = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window test on the entry read in the previous cycle, bounds included.
  assign window_match = (item.flash_time >= ram_rd_data.low) &&
                        (item.flash_time <= ram_rd_data.high);

  // Cosmic flash decision and tracking of the latest negative-time flash.
  assign cosmic_kept  = !hit;
  assign cosmic_track = cosmic_kept && item.flash_time[TIME_W-1] &&
                        (!latest_valid || (item.flash_time > latest_time));

  // Beam flash decision: signed time difference and charge ratio test.
  assign dt        = $signed({item.flash_time[TIME_W-1], item.flash_time}) -
                     $signed({latest_time[TIME_W-1], latest_time});
  assign dt_inside = dt < $signed({{(TIME_W + 1 - VETO_W){1'b0}}, veto_window});
  assign lhs       = {item.photo_charge, 8'h00};
  assign rhs       = 32'(pe_ratio) * 32'(latest_charge);
  assign beam_kept = !(latest_valid && dt_inside && (lhs < rhs));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      veto_window <= VETO_WINDOW_RESET;
      pe_ratio    <= PE_RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VETO_WINDOW: veto_window <= cfg_data;
        REG_PE_RATIO:    pe_ratio    <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Store fill count, overflow flag and the tracked cosmic flash.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count  <= '0;
      overflow      <= 1'b0;
      latest_valid  <= 1'b0;
      latest_time   <= '0;
      latest_charge <= '0;
    end else begin
      if (accept && (request.cmd == CMD_CLEAR)) begin
        window_count <= '0;
        overflow     <= 1'b0;
        latest_valid <= 1'b0;
      end
      if (accept && (request.cmd == CMD_LOAD)) begin
        if (store_full) begin
          overflow <= 1'b1;
        end else begin
          window_count <= window_count + WIN_CNT_W'(1);
        end
      end
      if (finish && (state == ST_SCAN) && cosmic_track) begin
        latest_valid  <= 1'b1;
        latest_time   <= item.flash_time;
        latest_charge <= item.photo_charge;
      end
    end
  end

  // Held transaction and scan progress.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
    end else if (accept) begin
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
    end else begin
      rd_pend <= ram_rd_en;
      if (ram_rd_en) begin
        issue_cnt <= issue_cnt + WIN_CNT_W'(1);
      end
      if (rd_pend && window_match) begin
        hit <= 1'b1;
      end
    end
  end

  // Result register: one pulse of done per judged flash.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.tag_out         <= item.flash_tag;
      result.kept            <= (state == ST_JUDGE) ? beam_kept : cosmic_kept;
      result.from_beam       <= (state == ST_JUDGE);
      result.window_overflow <= overflow;
    end
  end

  // A result only follows a cycle in which the block was busy.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // The fill count never passes the store depth.
  assert property (@(posedge clk) disable iff (rst)
    window_count <= WIN_CNT_W'(MAX_WINDOWS))
    else $error("window count beyond store depth");

  // A load into a full store sets the overflow flag.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (request.cmd == CMD_LOAD) && store_full) |=> overflow)
    else $error("overflow flag not set on load into full store");

  // The store is never read past its fill count.
  assert property (@(posedge clk) disable iff (rst)
    ram_rd_en |-> (issue_cnt < window_count) && (state == ST_SCAN))
    else $error("window store read beyond fill count");

endmodule

// ===== tb/tb_flash_coincidence_veto_unit.sv =====
// Self-checking testbench for flash_coincidence_veto_unit: directed and random flash traffic.
// It predicts every result in a small scoreboard class and checks it field by field.
// Depends on fcv_pkg and the flash_coincidence_veto_unit RTL.
module tb_flash_coincidence_veto_unit;
  import fcv_pkg::*;

  localparam int CLK_PERIOD       = 20;
  localparam int RESET_CYCLES     = 6;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int PHASE_COUNT      = 5;
  localparam int RANDOM_PER_PHASE = 100;

  // Predicts veto decisions and holds the results still to come.
  class veto_scoreboard;
    logic [VETO_W-1:0]  veto_window;
    logic [RATIO_W-1:0] pe_ratio;
    longint             win_low[MAX_WINDOWS];
    longint             win_high[MAX_WINDOWS];
    int                 window_count;
    longint             cosmic_time;
    longint             cosmic_charge;
    bit                 cosmic_valid;
    bit                 overflow;
    fcv_out_t           pending[$];
    int                 mismatches;

    function new();
      veto_window   = VETO_WINDOW_RESET;
      pe_ratio      = PE_RATIO_RESET;
      window_count  = 0;
      cosmic_time   = 0;
      cosmic_charge = 0;
      cosmic_valid  = 1'b0;
      overflow      = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_VETO_WINDOW) begin
        veto_window = data[VETO_W-1:0];
      end else begin
        pe_ratio = data[RATIO_W-1:0];
      end
    endfunction

    // Updates the mirrored state for an accepted transaction and queues its result.
    function void note_request(fcv_in_t req);
      longint   t;
      longint   lhs;
      longint   rhs;
      bit       keep;
      fcv_out_t res;
      t    = $signed(req.flash_time);
      keep = 1'b1;
      case (req.cmd)
        CMD_CLEAR: begin
          window_count = 0;
          cosmic_valid = 1'b0;
          overflow     = 1'b0;
          return;
        end
        CMD_LOAD: begin
          if (window_count < MAX_WINDOWS) begin
            win_low[window_count]  = $signed(req.window_low);
            win_high[window_count] = $signed(req.window_high);
            window_count++;
          end else begin
            overflow = 1'b1;
          end
          return;
        end
        CMD_COSMIC: begin
          // Any stored window that holds the time, bounds included, vetoes the flash.
          for (int i = 0; i < window_count; i++) begin
            if (t >= win_low[i] && t <= win_high[i]) keep = 1'b0;
          end
          // Track the latest kept cosmic flash before time zero; ties do not replace it.
          if (keep && t < 0 && (!cosmic_valid || t > cosmic_time)) begin
            cosmic_time   = t;
            cosmic_charge = longint'(req.photo_charge);
            cosmic_valid  = 1'b1;
          end
        end
        default: begin
          // Beam flash: signed time difference, charge compared against the scaled cosmic one.
          if (cosmic_valid) begin
            lhs = longint'(req.photo_charge) << 8;
            rhs = longint'(pe_ratio) * cosmic_charge;
            if (t - cosmic_time < longint'(veto_window) && lhs < rhs) keep = 1'b0;
          end
        end
      endcase
      res.tag_out         = req.flash_tag;
      res.kept            = keep;
      res.from_beam       = (req.cmd == CMD_BEAM);
      res.window_overflow = overflow;
      pending.insert(pending.size(), res);
    endfunction

    // Compares one result transaction with the oldest prediction.
    function void check_result(fcv_out_t got);
      fcv_out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: tag_out %0h kept %0b", got.tag_out, got.kept);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.tag_out !== want.tag_out) begin
        $error("tag_out: expected %0h, actual %0h", want.tag_out, got.tag_out);
        mismatches++;
      end
      if (got.kept !== want.kept) begin
        $error("kept: expected %0b, actual %0b", want.kept, got.kept);
        mismatches++;
      end
      if (got.from_beam !== want.from_beam) begin
        $error("from_beam: expected %0b, actual %0b", want.from_beam, got.from_beam);
        mismatches++;
      end
      if (got.window_overflow !== want.window_overflow) begin
        $error("window_overflow: expected %0b, actual %0b",
               want.window_overflow, got.window_overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  fcv_in_t               request;
  logic                  done;
  fcv_out_t              result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  veto_scoreboard sb = new();
  int             items_sent;
  int             next_gap;
  bit             no_idle;
  int             cycle_count;

  flash_coincidence_veto_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Result monitor: done is a single-cycle pulse, so every pulse is a transaction.
  always @(posedge clk) begin
    if (done === 1'b1) sb.check_result(result);
  end

  // Watchdog against a hung handshake or missing results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Builds a transaction with every field random, then sets the command.
  function automatic fcv_in_t random_item(logic [1:0] cmd);
    fcv_in_t item;
    item.cmd          = cmd;
    item.flash_time   = TIME_W'($urandom);
    item.window_low   = TIME_W'($urandom);
    item.window_high  = TIME_W'($urandom);
    item.photo_charge = CHARGE_W'($urandom);
    item.flash_tag    = TAG_W'($urandom);
    return item;
  endfunction

  // Issues one transaction. start stays high when the next one follows with no gap.
  task automatic send_request(input fcv_in_t item);
    repeat (next_gap) @(posedge clk);
    start   <= 1'b1;
    request <= item;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(item);
    items_sent++;
    next_gap = no_idle ? 0 : $urandom_range(0, 9);
    if (next_gap != 0) start <= 1'b0;
  endtask

  task automatic send_load(input int lo, input int hi);
    fcv_in_t item;
    item             = random_item(CMD_LOAD);
    item.window_low  = TIME_W'(lo);
    item.window_high = TIME_W'(hi);
    send_request(item);
  endtask

  task automatic send_flash(input logic [1:0] cmd, input int t, input int pe);
    fcv_in_t item;
    item              = random_item(cmd);
    item.flash_time   = TIME_W'(t);
    item.photo_charge = CHARGE_W'(pe);
    send_request(item);
  endtask

  // Drops start and waits until every result is in and the block has settled.
  task automatic wait_idle();
    if (next_gap == 0) start <= 1'b0;
    next_gap = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers; the unused upper data bits carry noise.
  task automatic program_registers(input logic [VETO_W-1:0] veto, input logic [RATIO_W-1:0] ratio);
    logic [CFG_DATA_W-1:0] data;
    data                = CFG_DATA_W'($urandom);
    data[RATIO_W-1:0]   = ratio;
    cfg_we    <= 1'b1;
    cfg_index <= REG_VETO_WINDOW;
    cfg_data  <= veto;
    sb.set_register(REG_VETO_WINDOW, veto);
    @(posedge clk);
    cfg_index <= REG_PE_RATIO;
    cfg_data  <= data;
    sb.set_register(REG_PE_RATIO, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One event: optional clear, a batch of windows, then mostly cosmic and beam flashes near a base time.
  task automatic random_sequence();
    int      base;
    int      win_total;
    int      lo;
    int      t;
    fcv_in_t item;
    no_idle = ($urandom_range(0, 3) == 0);
    base    = int'($urandom_range(0, 40000)) - 35000;
    if ($urandom_range(0, 9) != 0) send_request(random_item(CMD_CLEAR));
    case ($urandom_range(0, 9))
      0, 1:    win_total = $urandom_range(28, 34);
      default: win_total = $urandom_range(0, 6);
    endcase
    repeat (win_total) begin
      item = random_item(CMD_LOAD);
      lo   = base + int'($urandom_range(0, 8000)) - 4000;
      case ($urandom_range(0, 19))
        0: ; // full-range bounds
        1, 2: begin
          // Inverted window.
          item.window_low  = TIME_W'(lo);
          item.window_high = TIME_W'(lo - int'($urandom_range(1, 1500)));
        end
        default: begin
          item.window_low  = TIME_W'(lo);
          item.window_high = TIME_W'(lo + int'($urandom_range(0, 1500)));
        end
      endcase
      send_request(item);
    end
    repeat ($urandom_range(3, 12)) begin
      if ($urandom_range(0, 9) == 0) begin
        item = random_item(2'($urandom_range(0, 3)));
      end else begin
        item = random_item($urandom_range(0, 1) ? CMD_COSMIC : CMD_BEAM);
        if (item.cmd == CMD_COSMIC) begin
          t = base + int'($urandom_range(0, 6000)) - 3000;
        end else begin
          t = base + int'($urandom_range(0, 8000)) - 2000;
        end
        item.flash_time = TIME_W'(t);
        if ($urandom_range(0, 9) != 0) begin
          item.photo_charge = CHARGE_W'($urandom_range(0, 1 << 20));
        end
      end
      send_request(item);
    end
  endtask

  // Main stimulus.
  initial begin
    int phase_start;
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    cycle_count = 0;
    items_sent  = 0;
    next_gap    = 0;
    no_idle     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase != 0) begin
        wait_idle();
        case (phase)
          1:       program_registers(16'hFFFF, 8'd0);
          2:       program_registers(16'd0, 8'hFF);
          3:       program_registers(VETO_W'($urandom_range(0, 65535)),
                                     RATIO_W'($urandom_range(0, 255)));
          default: program_registers(16'hFFFF, 8'hFF);
        endcase
      end

      if (phase == 0) begin
        // No tracked cosmic flash yet, so the beam flash passes.
        send_flash(CMD_BEAM, 100, 0);
        send_request(random_item(CMD_CLEAR));
        send_load(-1000, -500);
        send_load(100, 50);
        send_load(-8388608, -8388600);
        send_load(8388600, 8388607);
        // Window bounds and time extremes veto cosmic flashes.
        send_flash(CMD_COSMIC, -1000, 1000);
        send_flash(CMD_COSMIC, -500, 1000);
        send_flash(CMD_COSMIC, -8388608, 1000);
        send_flash(CMD_COSMIC, 8388607, 1000);
        // Inside an inverted window, kept, but not tracked at positive time.
        send_flash(CMD_COSMIC, 75, 2000);
        send_flash(CMD_COSMIC, -499, 1600);
        // Equal and earlier times do not replace the tracked flash.
        send_flash(CMD_COSMIC, -499, 16);
        send_flash(CMD_COSMIC, -600, 16);
        send_flash(CMD_COSMIC, 0, 24'hFFFFFF);
        // Veto span edge: last vetoed ns, then first kept ns.
        send_flash(CMD_BEAM, 1900, 100);
        send_flash(CMD_BEAM, 1901, 100);
        // A beam flash before the cosmic one is inside the span.
        send_flash(CMD_BEAM, -8388608, 0);
        send_flash(CMD_BEAM, 1000, 24'hFFFFFF);
        // Charge threshold edge: first charge above the scaled one is kept, the last below
        // it is vetoed.
        send_flash(CMD_BEAM, 500, 1119);
        send_flash(CMD_BEAM, 500, 1118);
        send_flash(CMD_COSMIC, -100, 24'hFFFFFF);
        send_flash(CMD_BEAM, 8388607, 0);
        send_flash(CMD_BEAM, -100, 0);
      end

      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_PER_PHASE) random_sequence();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
